// ----- hdl/tra_pkg.sv -----
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types, opcodes and helpers of the task runtime accounting table.
// ----------------------------------------------------------------------------
package tra_pkg;

    localparam int MAX_TASKS_DEF = 32;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_STOP    = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_MON_ON  = 3'd4;
    localparam logic [2:0] OP_MON_OFF = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [14:0] id;
        logic [62:0] runtime;
        logic [62:0] resumed_at;
    } t_entry;

    // Clamp the register value to the legal range of system tasks.
    function automatic logic [3:0] f_clamp(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (r < 4'd1) r = 4'd1;
        if (r > 4'd8) r = 4'd8;
        return r;
    endfunction

    // Contents of slot idx after a table initialization with n system tasks.
    function automatic t_entry f_init(input int idx, input logic [3:0] n);
        t_entry e;
        e.valid      = (idx < int'(n));
        e.id         = (idx < int'(n)) ? 15'(idx) : 15'd0;
        e.runtime    = '0;
        e.resumed_at = '0;
        return e;
    endfunction

endpackage

// ----- hdl/tra_cell.sv -----
// ----------------------------------------------------------------------------
// tra_cell
// One slot of the ring; passes its entry to the neighbor while scanning.
// ----------------------------------------------------------------------------
module tra_cell #(
    parameter int INDEX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_init,
    input  logic [3:0]      i_sys_n,
    input  tra_pkg::t_entry i_next,
    output tra_pkg::t_entry o_entry
);
    import tra_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= f_init(INDEX, 4'd1);
        end else if (i_init) begin
            r_entry <= f_init(INDEX, i_sys_n);
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/tra_ctrl.sv -----
// ----------------------------------------------------------------------------
// tra_ctrl
// Sequencer at the head of the ring: updates each slot as it passes.
// ----------------------------------------------------------------------------
module tra_ctrl #(
    parameter int MAX_TASKS = tra_pkg::MAX_TASKS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_opcode,
    input  logic [14:0]     i_task_id,
    input  logic [62:0]     i_now_time,
    input  logic [4:0]      i_read_index,
    input  logic [3:0]      i_sys_n,
    input  tra_pkg::t_entry i_head,
    output tra_pkg::t_entry o_head,
    output logic            o_shift,
    output logic            o_busy,
    output logic            o_done,
    output logic            o_acted,
    output logic [4:0]      o_slot_index,
    output logic            o_slot_in_use,
    output logic [14:0]     o_slot_task_id,
    output logic [62:0]     o_slot_runtime,
    output logic [62:0]     o_window_start
);
    import tra_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state      r_state;
    logic [IW-1:0] r_k;
    logic [2:0]  r_op;
    logic [14:0] r_id;
    logic [62:0] r_now;
    logic [4:0]  r_ridx;
    logic        r_mon_zero;
    logic        r_found;
    logic [7:0]  r_mon;
    logic [62:0] r_window;
    logic        r_done;
    logic        r_acted;
    logic [4:0]  r_slot;
    logic        r_use;
    logic [14:0] r_tid;
    logic [62:0] r_rt;

    logic        w_hit;
    t_entry      w_mod;
    logic        w_sys;
    logic        w_match;
    logic        w_k_is_id;
    logic [62:0] w_delta;
    logic [63:0] w_sum;
    logic [62:0] w_add;

    assign w_sys     = (r_id < {11'd0, i_sys_n});
    assign w_match   = i_head.valid && (i_head.id == r_id);
    assign w_k_is_id = ({{(16-IW){1'b0}}, r_k} == {1'b0, r_id});
    assign w_delta   = (r_now >= i_head.resumed_at) ? (r_now - i_head.resumed_at) : 63'd0;
    assign w_sum     = {1'b0, i_head.runtime} + {1'b0, w_delta};
    assign w_add     = w_sum[63] ? {63{1'b1}} : w_sum[62:0];

    always_comb begin
        w_hit = 1'b0;
        w_mod = i_head;
        case (r_op)
            OP_START: begin
                w_hit = !r_found && !i_head.valid;
                if (w_hit) begin
                    w_mod.valid      = 1'b1;
                    w_mod.id         = r_id;
                    w_mod.runtime    = '0;
                    w_mod.resumed_at = '0;
                end
            end
            OP_STOP: begin
                w_hit = !r_found && w_match;
                if (w_hit) w_mod = '0;
            end
            OP_SUSPEND, OP_RESUME: begin
                w_hit = w_sys ? w_k_is_id : ((r_mon != 8'd0) && !r_found && w_match);
                if (w_hit) begin
                    if (r_op == OP_RESUME) begin
                        w_mod.resumed_at = r_now;
                    end else if (w_sys || (i_head.resumed_at != 63'd0)) begin
                        w_mod.runtime = w_add;
                    end
                end
            end
            OP_MON_ON: begin
                // Opening a window from zero clears the non-system slots.
                if (r_mon_zero && ({{(9-IW){1'b0}}, r_k} >= {5'd0, i_sys_n})) begin
                    w_mod.runtime    = '0;
                    w_mod.resumed_at = '0;
                end
            end
            OP_READ: begin
                w_hit = ({{(9-IW){1'b0}}, r_k} == {4'd0, r_ridx});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_mon    <= 8'd0;
            r_window <= '0;
            r_done   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op       <= i_opcode;
                        r_id       <= i_task_id;
                        r_now      <= i_now_time;
                        r_ridx     <= i_read_index;
                        r_mon_zero <= (r_mon == 8'd0);
                        r_found    <= 1'b0;
                        r_acted    <= (i_opcode == OP_MON_ON) || (i_opcode == OP_MON_OFF);
                        r_slot     <= '0;
                        r_use      <= 1'b0;
                        r_tid      <= '0;
                        r_rt       <= '0;
                        r_k        <= '0;
                        r_state    <= S_SCAN;
                        if (i_opcode == OP_MON_ON) begin
                            if (r_mon == 8'd0) r_window <= i_now_time;
                            if (r_mon != 8'd255) r_mon <= r_mon + 8'd1;
                        end else if (i_opcode == OP_MON_OFF) begin
                            r_mon <= (r_mon <= 8'd1) ? 8'd0 : r_mon - 8'd1;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_acted <= 1'b1;
                        r_slot  <= 5'(r_k);
                        r_use   <= w_mod.valid;
                        r_tid   <= w_mod.id;
                        r_rt    <= w_mod.runtime;
                    end
                    if (r_k == IW'(MAX_TASKS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_head         = w_mod;
    assign o_shift        = (r_state == S_SCAN);
    assign o_busy         = (r_state == S_SCAN);
    assign o_done         = r_done;
    assign o_acted        = r_acted;
    assign o_slot_index   = r_slot;
    assign o_slot_in_use  = r_use;
    assign o_slot_task_id = r_tid;
    assign o_slot_runtime = r_rt;
    assign o_window_start = r_window;

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_SCAN))
        else $error("result strobe without a finished scan");
    a_idle_k_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_k == '0))
        else $error("scan position not aligned while idle");
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while busy");

endmodule

// ----- hdl/task_runtime_accounting_table.sv -----
// ----------------------------------------------------------------------------
// task_runtime_accounting_table
// Per-task runtime accounting over a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// Every item rotates the slot ring once past the head sequencer, one slot per
// cycle, with busy high while the ring rotates; the result strobe is registered
// as the last slot passes. The next item may start in the cycle that carries
// the strobe. The strobe is high for a single cycle, the result stays on the
// ports until the next item starts, and the receiver cannot stall it.
module task_runtime_accounting_table #(
    parameter int MAX_TASKS = tra_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic [2:0]  i_opcode,
    input  logic [14:0] i_task_id,
    input  logic [62:0] i_now_time,
    input  logic [4:0]  i_read_index,
    output logic        o_done,
    output logic        o_acted,
    output logic [4:0]  o_slot_index,
    output logic        o_slot_in_use,
    output logic [14:0] o_slot_task_id,
    output logic [62:0] o_slot_runtime,
    output logic [62:0] o_window_start
);
    import tra_pkg::*;

    logic [3:0] r_sys_n;
    logic [3:0] w_cfg_n;
    logic       w_shift;
    t_entry     w_head_mod;
    t_entry     w_cell [MAX_TASKS];

    always_comb begin
        w_cfg_n = f_clamp(i_cfg_wdata);
        if (int'(w_cfg_n) > MAX_TASKS) w_cfg_n = 4'(MAX_TASKS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_n <= 4'd1;
        end else if (i_cfg_we) begin
            r_sys_n <= w_cfg_n;
        end
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        if (g == MAX_TASKS - 1) begin : g_tail
            tra_cell #(.INDEX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_init  (i_cfg_we),
                .i_sys_n (w_cfg_n),
                .i_next  (w_head_mod),
                .o_entry (w_cell[g])
            );
        end else begin : g_body
            tra_cell #(.INDEX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_init  (i_cfg_we),
                .i_sys_n (w_cfg_n),
                .i_next  (w_cell[g+1]),
                .o_entry (w_cell[g])
            );
        end
    end

    tra_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_task_id      (i_task_id),
        .i_now_time     (i_now_time),
        .i_read_index   (i_read_index),
        .i_sys_n        (r_sys_n),
        .i_head         (w_cell[0]),
        .o_head         (w_head_mod),
        .o_shift        (w_shift),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_acted        (o_acted),
        .o_slot_index   (o_slot_index),
        .o_slot_in_use  (o_slot_in_use),
        .o_slot_task_id (o_slot_task_id),
        .o_slot_runtime (o_slot_runtime),
        .o_window_start (o_window_start)
    );

endmodule

// ----- test/tra_checker.sv -----
// ----------------------------------------------------------------------------
// tra_checker
// Watches the item, result and register ports of the accounting table,
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tra_checker #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic [2:0]  i_opcode,
    input  logic [14:0] i_task_id,
    input  logic [62:0] i_now_time,
    input  logic [4:0]  i_read_index,
    input  logic        o_done,
    input  logic        o_acted,
    input  logic [4:0]  o_slot_index,
    input  logic        o_slot_in_use,
    input  logic [14:0] o_slot_task_id,
    input  logic [62:0] o_slot_runtime,
    input  logic [62:0] o_window_start,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tra_pkg::*;

    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    typedef struct {
        logic        acted;
        logic [4:0]  slot;
        logic        in_use;
        logic [14:0] task_id;
        logic [62:0] runtime;
        logic [62:0] window;
    } t_slot_report;

    t_slot_report reports_due[$];

    logic [3:0]  sys_reg;
    logic        slot_used [SLOTS];
    logic [14:0] slot_owner [SLOTS];
    logic [62:0] slot_total [SLOTS];
    logic [62:0] slot_since [SLOTS];
    int          tasks_live;
    int          watchers;
    logic [62:0] window_t0;

    function automatic int sys_tasks();
        int n;
        n = int'(sys_reg);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    function automatic void rebuild_table();
        int n;
        n = sys_tasks();
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = (i < n);
            slot_owner[i] = (i < n) ? 15'(i) : 15'd0;
            slot_total[i] = '0;
            slot_since[i] = '0;
        end
        tasks_live = n;
    endfunction

    function automatic void charge(int s, logic [62:0] t_now);
        logic [63:0] sum;
        logic [62:0] d;
        d   = (t_now >= slot_since[s]) ? t_now - slot_since[s] : 63'd0;
        sum = {1'b0, slot_total[s]} + {1'b0, d};
        slot_total[s] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[62:0];
    endfunction

    function automatic int owner_slot(logic [14:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_owner[i] == id) return i;
        return -1;
    endfunction

    function automatic t_slot_report account_event(logic [2:0] op, logic [14:0] id,
                                                   logic [62:0] t_now, logic [4:0] ridx);
        t_slot_report r;
        int s;
        int n;
        logic hit;
        s   = -1;
        n   = sys_tasks();
        hit = 1'b0;
        case (op)
            OP_START: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (s < 0 && !slot_used[i]) begin
                        slot_used[i]  = 1'b1;
                        slot_owner[i] = id;
                        slot_total[i] = '0;
                        slot_since[i] = '0;
                        if (tasks_live < 63) tasks_live++;
                        s = i;
                    end
                end
            end
            OP_STOP: begin
                s = owner_slot(id);
                if (s >= 0) begin
                    slot_used[s]  = 1'b0;
                    slot_owner[s] = '0;
                    slot_total[s] = '0;
                    slot_since[s] = '0;
                    if (tasks_live > 0) tasks_live--;
                end
            end
            OP_SUSPEND, OP_RESUME: begin
                if (int'(id) < n) begin
                    s = int'(id);
                    if (op == OP_SUSPEND) charge(s, t_now);
                    else slot_since[s] = t_now;
                end else if (watchers != 0) begin
                    s = owner_slot(id);
                    if (s >= 0) begin
                        if (op == OP_RESUME) slot_since[s] = t_now;
                        else if (slot_since[s] > 0) charge(s, t_now);
                    end
                end
            end
            OP_MON_ON: begin
                if (watchers == 0) begin
                    window_t0 = t_now;
                    for (int i = n; i < SLOTS; i++) begin
                        slot_total[i] = '0;
                        slot_since[i] = '0;
                    end
                end
                if (watchers < 255) watchers++;
                hit = 1'b1;
            end
            OP_MON_OFF: begin
                if (watchers <= 1) watchers = 0;
                else watchers--;
                hit = 1'b1;
            end
            OP_READ: begin
                if (int'(ridx) < SLOTS) s = int'(ridx);
            end
            default: ;
        endcase
        if (s >= 0) begin
            r.acted   = 1'b1;
            r.slot    = 5'(s);
            r.in_use  = slot_used[s];
            r.task_id = slot_owner[s];
            r.runtime = slot_total[s];
        end else begin
            r.acted   = hit;
            r.slot    = '0;
            r.in_use  = 1'b0;
            r.task_id = '0;
            r.runtime = '0;
        end
        r.window = window_t0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_report want;
        if (!i_rst_n) begin
            watchers  = 0;
            window_t0 = '0;
            reports_due.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
            sys_reg = 4'd1;
            rebuild_table();
        end else begin
            if (o_done) begin
                o_result_count <= o_result_count + 1;
                if (reports_due.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reports_due.pop_front();
                    if (o_acted !== want.acted ||
                        o_slot_index !== want.slot ||
                        o_slot_in_use !== want.in_use ||
                        o_slot_task_id !== want.task_id ||
                        o_slot_runtime !== want.runtime ||
                        o_window_start !== want.window)
                        o_fail_count <= o_fail_count + 1;
                    if (o_acted !== want.acted)
                        $error("acted: expected %0d, got %0d", want.acted, o_acted);
                    if (o_slot_index !== want.slot)
                        $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                    if (o_slot_in_use !== want.in_use)
                        $error("slot_in_use: expected %0d, got %0d",
                               want.in_use, o_slot_in_use);
                    if (o_slot_task_id !== want.task_id)
                        $error("slot_task_id: expected %0d, got %0d",
                               want.task_id, o_slot_task_id);
                    if (o_slot_runtime !== want.runtime)
                        $error("slot_runtime: expected %0d, got %0d",
                               want.runtime, o_slot_runtime);
                    if (o_window_start !== want.window)
                        $error("window_start: expected %0d, got %0d",
                               want.window, o_window_start);
                end
            end
            if (i_cfg_we) begin
                sys_reg = i_cfg_wdata;
                rebuild_table();
            end
            if (start && !busy)
                reports_due.push_back(account_event(i_opcode, i_task_id,
                                                    i_now_time, i_read_index));
        end
        o_pending <= reports_due.size();
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the task runtime accounting table: directed
// events, then phases of random scheduler traffic under several settings of
// the system task count, with random gaps between items.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tra_pkg::*;

    localparam logic [2:0]  OP_UNUSED   = 3'd7;
    localparam logic [62:0] TIME_MAX    = {63{1'b1}};
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN       = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;
    logic [2:0]  i_opcode;
    logic [14:0] i_task_id;
    logic [62:0] i_now_time;
    logic [4:0]  i_read_index;
    logic        o_done;
    logic        o_acted;
    logic [4:0]  o_slot_index;
    logic        o_slot_in_use;
    logic [14:0] o_slot_task_id;
    logic [62:0] o_slot_runtime;
    logic [62:0] o_window_start;
    int          fail_count;
    int          pending;
    int          result_count;
    int          cycles;
    int          items_sent;
    int          max_gap;
    logic [62:0] clock_us;

    task_runtime_accounting_table DUT (.*);

    tra_checker #(.SLOTS(MAX_TASKS_DEF)) u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Start stays high from one item to the next when there is no gap.
    task automatic send_event(logic [2:0] op, logic [14:0] id, logic [62:0] t_now,
                              logic [4:0] ridx);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_task_id    <= id;
        i_now_time   <= t_now;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_sys_count(logic [3:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic logic [14:0] pick_id();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return 15'($urandom_range(0, 8));
        if (p < 80) return 15'($urandom_range(8, 23));
        return 15'($urandom);
    endfunction

    function automatic logic [62:0] next_time();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4) clock_us = rand63();
        else if (p < 7) clock_us = clock_us - 63'($urandom_range(0, 500));
        else clock_us = clock_us + 63'($urandom_range(0, 1000));
        return clock_us;
    endfunction

    // Mostly well-formed scheduler traffic over a small pool of task ids.
    task automatic random_phase(int count, bit monitor_stress);
        int p;
        logic [2:0] op;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
            p = $urandom_range(0, 99);
            if (monitor_stress) op = (k < count / 2) ? OP_MON_ON : OP_MON_OFF;
            else if (p < 20) op = OP_START;
            else if (p < 32) op = OP_STOP;
            else if (p < 52) op = OP_SUSPEND;
            else if (p < 72) op = OP_RESUME;
            else if (p < 78) op = OP_MON_ON;
            else if (p < 83) op = OP_MON_OFF;
            else if (p < 97) op = OP_READ;
            else op = OP_UNUSED;
            send_event(op, pick_id(), next_time(), 5'($urandom));
        end
    endtask

    initial begin
        logic [3:0] settings [6];
        items_sent   = 0;
        max_gap      = 17;
        clock_us     = '0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_opcode     = OP_READ;
        i_task_id    = '0;
        i_now_time   = '0;
        i_read_index = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events at the reset setting of one system task.
        send_event(OP_READ, 15'd0, 63'd0, 5'd0);
        send_event(OP_READ, 15'd0, 63'd0, 5'd31);
        send_event(OP_RESUME, 15'd0, 63'd0, 5'd0);
        send_event(OP_SUSPEND, 15'd0, TIME_MAX, 5'd0);
        // The second charge overflows and must saturate.
        send_event(OP_SUSPEND, 15'd0, 63'd5, 5'd0);
        send_event(OP_RESUME, 15'd0, 63'd100, 5'd0);
        // Time running backwards adds nothing.
        send_event(OP_SUSPEND, 15'd0, 63'd50, 5'd0);
        send_event(OP_START, 15'd100, 63'd60, 5'd0);
        send_event(OP_RESUME, 15'd100, 63'd70, 5'd0);
        send_event(OP_MON_OFF, 15'd0, 63'd80, 5'd0);
        send_event(OP_MON_ON, 15'd0, 63'd777, 5'd0);
        // A suspend before any resume finds the slot but charges nothing.
        send_event(OP_SUSPEND, 15'd100, 63'd900, 5'd0);
        send_event(OP_RESUME, 15'd100, 63'd1000, 5'd0);
        send_event(OP_SUSPEND, 15'd100, 63'd1300, 5'd0);
        send_event(OP_START, 15'h7fff, TIME_MAX, 5'd0);
        send_event(OP_STOP, 15'd100, 63'd0, 5'd0);
        send_event(OP_STOP, 15'd100, 63'd0, 5'd0);
        send_event(OP_STOP, 15'd0, 63'd0, 5'd0);
        send_event(OP_UNUSED, 15'h7fff, TIME_MAX, 5'd31);
        send_event(OP_MON_ON, 15'd0, 63'd5, 5'd0);
        send_event(OP_MON_OFF, 15'd0, 63'd6, 5'd0);
        send_event(OP_MON_OFF, 15'd0, 63'd7, 5'd0);
        send_event(OP_MON_OFF, 15'd0, 63'd8, 5'd0);

        settings = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd4, 4'($urandom_range(2, 7))};
        for (int ph = 0; ph < 6; ph++) begin
            write_sys_count(settings[ph]);
            random_phase(180, 1'b0);
            // The nesting count is driven past its ceiling once.
            if (ph == 2) random_phase(540, 1'b1);
        end

        settle();
        $display("tb: %0d items sent, %0d results checked over six register settings",
                 items_sent, result_count);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
